@@ rtl/core/omni_wheel_odometry_defines.svh @@
// ----------------------------------------------------------------------------
// omni_wheel_odometry_defines.svh
// Assertion macros shared by the odometry RTL.
// ----------------------------------------------------------------------------
`ifndef OMNI_WHEEL_ODOMETRY_DEFINES_SVH
`define OMNI_WHEEL_ODOMETRY_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define OWO_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("odometry core: property violated");

// Next-cycle implication, disabled while reset is asserted
`define OWO_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("odometry core: property violated");

`endif

@@ rtl/core/owo_pkg.sv @@
// ----------------------------------------------------------------------------
// owo_pkg
// Widths, constants and types of the omni wheel odometry core.
// ----------------------------------------------------------------------------
`default_nettype none

package owo_pkg;

	// Field widths
	localparam int SPEED_W   = 16;
	localparam int DT_W      = 16;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int VEL_W     = 32;
	localparam int ACC_W     = 48;

	// Combined wheel speed: sum of four Q7.8 values
	localparam int WS_W = SPEED_W + 2;

	// Shared multiplier: signed A times unsigned B
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 16;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W + 1;

	// 0.7071 / 4 in unsigned Q0.16
	localparam logic [MUL_B_W-1:0] KXY_Q16 = 16'd11585;

	// Shifts that bring products back to Q15.16
	localparam int SHIFT_XY   = 24;
	localparam int SHIFT_TURN = 18;
	localparam int SHIFT_DT   = 16;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_WHEEL_RADIUS   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_WHEEL_BASE = 2'd1;

	// Register reset values
	localparam logic [CFG_W-1:0] WHEEL_RADIUS_RST   = 16'd3277;
	localparam logic [CFG_W-1:0] INV_WHEEL_BASE_RST = 16'd1280;

	// Operation codes
	localparam logic OP_WHEEL = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// Sequencer steps
	localparam int STEP_W = 3;
	localparam logic [STEP_W-1:0] WHEEL_LAST_STEP = 3'd6;
	localparam logic [STEP_W-1:0] TICK_LAST_STEP  = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// Request to the shared multiplier
	typedef struct packed {
		logic                      en;
		logic signed [MUL_A_W-1:0] a;
		logic        [MUL_B_W-1:0] b;
	} mul_req_t;

endpackage

`default_nettype wire

@@ rtl/core/owo_item_if.sv @@
// ----------------------------------------------------------------------------
// owo_item_if
// Input item channel: wheel speed update or time tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface owo_item_if;
	logic                                 valid;
	logic                                 ready;
	logic                                 operation;
	logic signed [owo_pkg::SPEED_W-1:0]   wheel_speed_1;
	logic signed [owo_pkg::SPEED_W-1:0]   wheel_speed_2;
	logic signed [owo_pkg::SPEED_W-1:0]   wheel_speed_3;
	logic signed [owo_pkg::SPEED_W-1:0]   wheel_speed_4;
	logic        [owo_pkg::DT_W-1:0]      elapsed_time;

	modport source (
		output valid, operation, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		       wheel_speed_4, elapsed_time,
		input  ready
	);

	modport sink (
		input  valid, operation, wheel_speed_1, wheel_speed_2, wheel_speed_3,
		       wheel_speed_4, elapsed_time,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/owo_result_if.sv @@
// ----------------------------------------------------------------------------
// owo_result_if
// Result item channel: pose and body velocities.
// ----------------------------------------------------------------------------
`default_nettype none

interface owo_result_if;
	logic                               valid;
	logic                               ready;
	logic signed [owo_pkg::ACC_W-1:0]   pos_x;
	logic signed [owo_pkg::ACC_W-1:0]   pos_y;
	logic signed [owo_pkg::ACC_W-1:0]   heading;
	logic signed [owo_pkg::VEL_W-1:0]   vel_x;
	logic signed [owo_pkg::VEL_W-1:0]   vel_y;
	logic signed [owo_pkg::VEL_W-1:0]   vel_turn;

	modport source (
		output valid, pos_x, pos_y, heading, vel_x, vel_y, vel_turn,
		input  ready
	);

	modport sink (
		input  valid, pos_x, pos_y, heading, vel_x, vel_y, vel_turn,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/owo_cfg_if.sv @@
// ----------------------------------------------------------------------------
// owo_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface owo_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [owo_pkg::CFG_IDX_W-1:0]      reg_index;
	logic [owo_pkg::CFG_W-1:0]          data;

	modport source (
		output valid, reg_index, data,
		input  ready
	);

	modport sink (
		input  valid, reg_index, data,
		output ready
	);
endinterface

`default_nettype wire

@@ rtl/core/omni_wheel_odometry.sv @@
// ----------------------------------------------------------------------------
// omni_wheel_odometry
// Forward kinematics and pose integration for a four-wheel omni base.
// ----------------------------------------------------------------------------
// A wheel item sets the body x, y and turn velocities (Q15.16) from four wheel
// speeds; a tick item adds velocity times elapsed time to x, y and heading
// (Q31.16, saturating, heading not wrapped, no rotation by heading). Every item
// returns one result with the pose and velocities after it. All products go
// through one shared 34x17 multiplier, one product per cycle under a step
// counter: a wheel item takes six products and a tick item three. An item
// runs its steps in the run state, then waits in the done state until the
// result register is loaded. The core takes no new item meanwhile and goes
// back to idle as the result is loaded, so each item is through first.
// The result sits in an output register; while a stalled receiver leaves it
// full, the finished item waits and the core stays busy. Configuration writes
// are taken in every cycle.
`default_nettype none

`include "omni_wheel_odometry_defines.svh"

module omni_wheel_odometry (
	input  wire logic     clk,
	input  wire logic     arst_n,
	owo_item_if.sink      item_in,
	owo_result_if.source  result_out,
	owo_cfg_if.sink       cfg
);

	localparam int VSUM_W = owo_pkg::MUL_P_W + 1;
	localparam int ASUM_W = owo_pkg::ACC_W + 1;

	// ------------------------------------------------------------------------
	// Saturation helpers
	// ------------------------------------------------------------------------
	function automatic logic signed [owo_pkg::VEL_W-1:0] sat_vel(
		input logic signed [VSUM_W-1:0] v
	);
		logic signed [VSUM_W-1:0] vmax;
		logic signed [VSUM_W-1:0] vmin;
		vmax = VSUM_W'($signed({1'b0, {(owo_pkg::VEL_W-1){1'b1}}}));
		vmin = VSUM_W'($signed({1'b1, {(owo_pkg::VEL_W-1){1'b0}}}));
		if (v > vmax) begin
			sat_vel = vmax[owo_pkg::VEL_W-1:0];
		end else if (v < vmin) begin
			sat_vel = vmin[owo_pkg::VEL_W-1:0];
		end else begin
			sat_vel = v[owo_pkg::VEL_W-1:0];
		end
	endfunction

	function automatic logic signed [owo_pkg::ACC_W-1:0] sat_acc(
		input logic signed [ASUM_W-1:0] v
	);
		logic signed [ASUM_W-1:0] amax;
		logic signed [ASUM_W-1:0] amin;
		amax = ASUM_W'($signed({1'b0, {(owo_pkg::ACC_W-1){1'b1}}}));
		amin = ASUM_W'($signed({1'b1, {(owo_pkg::ACC_W-1){1'b0}}}));
		if (v > amax) begin
			sat_acc = amax[owo_pkg::ACC_W-1:0];
		end else if (v < amin) begin
			sat_acc = amin[owo_pkg::ACC_W-1:0];
		end else begin
			sat_acc = v[owo_pkg::ACC_W-1:0];
		end
	endfunction

	// ------------------------------------------------------------------------
	// Declarations
	// ------------------------------------------------------------------------
	owo_pkg::state_t state_q, state_d;

	logic [owo_pkg::CFG_W-1:0] wheel_radius_q;
	logic [owo_pkg::CFG_W-1:0] inv_wheel_base_q;

	logic                             op_q;
	logic [owo_pkg::STEP_W-1:0]       step_q;
	logic [owo_pkg::STEP_W-1:0]       last_step;
	logic signed [owo_pkg::WS_W-1:0]  ws_x_q, ws_y_q, ws_t_q;
	logic [owo_pkg::DT_W-1:0]         dt_q;

	logic signed [owo_pkg::VEL_W-1:0] body_speed_x_q, body_speed_y_q, turn_rate_q;
	logic signed [owo_pkg::ACC_W-1:0] pos_x_acc_q, pos_y_acc_q, heading_acc_q;

	logic                             out_valid_q;
	logic signed [owo_pkg::ACC_W-1:0] out_pos_x_q, out_pos_y_q, out_heading_q;
	logic signed [owo_pkg::VEL_W-1:0] out_vel_x_q, out_vel_y_q, out_vel_turn_q;

	logic item_accept;
	logic load_out;
	logic running;

	owo_pkg::mul_req_t                    mul_req;
	logic signed [owo_pkg::MUL_P_W-1:0]   mul_q;

	logic                             retire;
	logic [1:0]                       retire_sel;
	logic signed [VSUM_W-1:0]         neg_prod;
	logic signed [VSUM_W-1:0]         vel_shifted;
	logic signed [owo_pkg::VEL_W-1:0] vel_new;
	logic signed [owo_pkg::ACC_W-1:0] acc_cur;
	logic signed [ASUM_W-1:0]         acc_sum;
	logic signed [owo_pkg::ACC_W-1:0] acc_new;

	logic signed [owo_pkg::WS_W-1:0]  w1, w2, w3, w4;

	// ------------------------------------------------------------------------
	// Configuration registers
	// ------------------------------------------------------------------------
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wheel_radius_q   <= owo_pkg::WHEEL_RADIUS_RST;
			inv_wheel_base_q <= owo_pkg::INV_WHEEL_BASE_RST;
		end else if (cfg.valid) begin
			if (cfg.reg_index == owo_pkg::REG_WHEEL_RADIUS) begin
				wheel_radius_q <= cfg.data;
			end else if (cfg.reg_index == owo_pkg::REG_INV_WHEEL_BASE) begin
				inv_wheel_base_q <= cfg.data;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------------
	assign item_accept = item_in.valid && item_in.ready;
	assign running     = (state_q == owo_pkg::ST_RUN);
	assign last_step   = (op_q == owo_pkg::OP_TICK) ? owo_pkg::TICK_LAST_STEP
	                                                : owo_pkg::WHEEL_LAST_STEP;

	always_comb begin
		state_d       = state_q;
		item_in.ready = 1'b0;
		load_out      = 1'b0;
		unique case (state_q)
			owo_pkg::ST_IDLE: begin
				item_in.ready = 1'b1;
				if (item_in.valid) begin
					state_d = owo_pkg::ST_RUN;
				end
			end
			owo_pkg::ST_RUN: begin
				if (step_q == last_step) begin
					state_d = owo_pkg::ST_DONE;
				end
			end
			owo_pkg::ST_DONE: begin
				if (!out_valid_q || result_out.ready) begin
					load_out = 1'b1;
					state_d  = owo_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = owo_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= owo_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (item_accept) begin
				step_q <= '0;
			end else if (running && step_q != last_step) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Capture the item: fold the wheel speeds into three signed sums
	// ------------------------------------------------------------------------
	assign w1 = owo_pkg::WS_W'(item_in.wheel_speed_1);
	assign w2 = owo_pkg::WS_W'(item_in.wheel_speed_2);
	assign w3 = owo_pkg::WS_W'(item_in.wheel_speed_3);
	assign w4 = owo_pkg::WS_W'(item_in.wheel_speed_4);

	always_ff @(posedge clk) begin
		if (item_accept) begin
			op_q   <= item_in.operation;
			ws_x_q <= w1 - w2 - w3 + w4;
			ws_y_q <= w1 + w2 - w3 - w4;
			ws_t_q <= w1 + w2 + w3 + w4;
			dt_q   <= item_in.elapsed_time;
		end
	end

	// ------------------------------------------------------------------------
	// Multiplier operands per step
	// ------------------------------------------------------------------------
	always_comb begin
		mul_req.en = running && (step_q != last_step);
		mul_req.a  = '0;
		mul_req.b  = '0;
		if (op_q == owo_pkg::OP_TICK) begin
			unique case (step_q)
				3'd0: mul_req.a = owo_pkg::MUL_A_W'(body_speed_x_q);
				3'd1: mul_req.a = owo_pkg::MUL_A_W'(body_speed_y_q);
				3'd2: mul_req.a = owo_pkg::MUL_A_W'(turn_rate_q);
				default: mul_req.a = '0;
			endcase
			mul_req.b = dt_q;
		end else begin
			// Even steps start a chain from a sum, odd steps reuse the product
			unique case (step_q)
				3'd0: begin
					mul_req.a = owo_pkg::MUL_A_W'(ws_x_q);
					mul_req.b = owo_pkg::KXY_Q16;
				end
				3'd1: begin
					mul_req.a = mul_q[owo_pkg::MUL_A_W-1:0];
					mul_req.b = wheel_radius_q;
				end
				3'd2: begin
					mul_req.a = owo_pkg::MUL_A_W'(ws_y_q);
					mul_req.b = owo_pkg::KXY_Q16;
				end
				3'd3: begin
					mul_req.a = mul_q[owo_pkg::MUL_A_W-1:0];
					mul_req.b = wheel_radius_q;
				end
				3'd4: begin
					mul_req.a = owo_pkg::MUL_A_W'(ws_t_q);
					mul_req.b = wheel_radius_q;
				end
				3'd5: begin
					mul_req.a = mul_q[owo_pkg::MUL_A_W-1:0];
					mul_req.b = inv_wheel_base_q;
				end
				default: begin
					mul_req.a = '0;
					mul_req.b = '0;
				end
			endcase
		end
	end

	owo_mul_unit u_mul (
		.clk       (clk),
		.req       (mul_req),
		.product_q (mul_q)
	);

	// ------------------------------------------------------------------------
	// Retire a finished product: 0 = x, 1 = y, 2 = turn
	// ------------------------------------------------------------------------
	always_comb begin
		retire     = 1'b0;
		retire_sel = 2'd0;
		if (running) begin
			if (op_q == owo_pkg::OP_TICK) begin
				unique case (step_q)
					3'd1: begin retire = 1'b1; retire_sel = 2'd0; end
					3'd2: begin retire = 1'b1; retire_sel = 2'd1; end
					3'd3: begin retire = 1'b1; retire_sel = 2'd2; end
					default: retire = 1'b0;
				endcase
			end else begin
				unique case (step_q)
					3'd2: begin retire = 1'b1; retire_sel = 2'd0; end
					3'd4: begin retire = 1'b1; retire_sel = 2'd1; end
					3'd6: begin retire = 1'b1; retire_sel = 2'd2; end
					default: retire = 1'b0;
				endcase
			end
		end
	end

	// Velocity: rim speed is minus radius times wheel speed
	always_comb begin
		neg_prod = -VSUM_W'(mul_q);
		if (retire_sel == 2'd2) begin
			vel_shifted = neg_prod >>> owo_pkg::SHIFT_TURN;
		end else begin
			vel_shifted = neg_prod >>> owo_pkg::SHIFT_XY;
		end
		vel_new = sat_vel(vel_shifted);
	end

	// Pose: add the scaled increment to the selected accumulator
	always_comb begin
		unique case (retire_sel)
			2'd0:    acc_cur = pos_x_acc_q;
			2'd1:    acc_cur = pos_y_acc_q;
			default: acc_cur = heading_acc_q;
		endcase
		acc_sum = ASUM_W'(acc_cur) + ASUM_W'(mul_q >>> owo_pkg::SHIFT_DT);
		acc_new = sat_acc(acc_sum);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			body_speed_x_q <= '0;
			body_speed_y_q <= '0;
			turn_rate_q    <= '0;
			pos_x_acc_q    <= '0;
			pos_y_acc_q    <= '0;
			heading_acc_q  <= '0;
		end else if (retire) begin
			if (op_q == owo_pkg::OP_TICK) begin
				unique case (retire_sel)
					2'd0:    pos_x_acc_q   <= acc_new;
					2'd1:    pos_y_acc_q   <= acc_new;
					default: heading_acc_q <= acc_new;
				endcase
			end else begin
				unique case (retire_sel)
					2'd0:    body_speed_x_q <= vel_new;
					2'd1:    body_speed_y_q <= vel_new;
					default: turn_rate_q    <= vel_new;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_pos_x_q    <= pos_x_acc_q;
			out_pos_y_q    <= pos_y_acc_q;
			out_heading_q  <= heading_acc_q;
			out_vel_x_q    <= body_speed_x_q;
			out_vel_y_q    <= body_speed_y_q;
			out_vel_turn_q <= turn_rate_q;
		end
	end

	assign result_out.valid    = out_valid_q;
	assign result_out.pos_x    = out_pos_x_q;
	assign result_out.pos_y    = out_pos_y_q;
	assign result_out.heading  = out_heading_q;
	assign result_out.vel_x    = out_vel_x_q;
	assign result_out.vel_y    = out_vel_y_q;
	assign result_out.vel_turn = out_vel_turn_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	`OWO_ASSERT_NXT(a_accept_starts_run, clk, arst_n, item_accept, running && step_q == '0)
	`OWO_ASSERT_IMP(a_step_in_range, clk, arst_n, running, step_q <= last_step)
	`OWO_ASSERT_NXT(a_done_holds, clk, arst_n,
		state_q == owo_pkg::ST_DONE && out_valid_q && !result_out.ready,
		state_q == owo_pkg::ST_DONE)
	`OWO_ASSERT_IMP(a_no_retire_idle, clk, arst_n, !running, !retire && !mul_req.en)

endmodule

`default_nettype wire

@@ rtl/core/owo_mul_unit.sv @@
// ----------------------------------------------------------------------------
// owo_mul_unit
// Shared signed-by-unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module owo_mul_unit (
	input  wire logic                                     clk,
	input  wire owo_pkg::mul_req_t                        req,
	output logic signed [owo_pkg::MUL_P_W-1:0]            product_q
);

	logic signed [owo_pkg::MUL_P_W-1:0] product;

	// Extend B with a zero sign bit so the product stays signed
	assign product = req.a * $signed({1'b0, req.b});

	// Hold the product until the next request
	always_ff @(posedge clk) begin
		if (req.en) begin
			product_q <= product;
		end
	end

endmodule

`default_nettype wire
